// ===== design/mrgw_pkg.sv =====
// mrgw_pkg: shared widths, codes and handshake structs for the grid walker
// used by mrgw_div and mixed_radix_grid_walker_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrgw_pkg;

  localparam int NUM_DIMS_DEF  = 4;
  localparam int SIZE_BITS_DEF = 12;
  localparam int CNT_BITS      = 48;
  localparam int NUM_CFG       = 4;
  localparam int CFG_IDX_W     = $clog2(NUM_CFG);
  localparam int NUM_POS       = 4;

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  typedef enum logic {
    CMD_SETUP   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_COUNT = 2'd1,
    ST_CLIPPED    = 2'd2
  } status_t;

  typedef struct packed {
    logic start;
    logic short_mode;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/mixed_radix_grid_walker_unit.sv =====
// advance: walks the active dimensions from accept to out_valid; a dimension whose
//   sum reaches twice its size goes through the shared divider in short mode
// setup: every division runs the 48-bit divider in full mode;
//   zero-count setup answers without dividing. one item at a time, in_ready only when idle,
//   next accept only once the result is taken and the unit is back in idle
// reset (synchronous, rst_n low) clears sizes, positions, stride digits and the sequencer
`timescale 1ns / 1ps
`default_nettype none

module mixed_radix_grid_walker_unit #(
  parameter int NUM_DIMS  = mrgw_pkg::NUM_DIMS_DEF,
  parameter int SIZE_BITS = mrgw_pkg::SIZE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [mrgw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [SIZE_BITS-1:0]                cfg_data,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_cmd,
  input  wire [mrgw_pkg::CNT_BITS-1:0]       in_sample_count,
  input  wire [mrgw_pkg::CNT_BITS-1:0]       in_start_offset,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [SIZE_BITS-1:0]               out_pos_0,
  output logic [SIZE_BITS-1:0]               out_pos_1,
  output logic [SIZE_BITS-1:0]               out_pos_2,
  output logic [SIZE_BITS-1:0]               out_pos_3,
  output logic                               out_more_left,
  output logic [mrgw_pkg::CNT_BITS-1:0]      out_used_count,
  output logic [1:0]                         out_status
);
  import mrgw_pkg::*;

  localparam int IDX_W  = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
  localparam int CNT_W  = $clog2(NUM_DIMS + 1);
  localparam int SUM_W  = SIZE_BITS + 1 + $clog2(NUM_DIMS + 1);
  localparam int PROD_W = CNT_BITS + SIZE_BITS;

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_PROD       = 9'b000000010,
    S_CLIP       = 9'b000000100,
    S_QDIV       = 9'b000001000,
    S_SPLIT_OFF  = 9'b000010000,
    S_SPLIT_STEP = 9'b000100000,
    S_ADV        = 9'b001000000,
    S_ADV_DIV    = 9'b010000000,
    S_OUT        = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  launched_r, launched_nxt;
  logic [SIZE_BITS-1:0]  dim_size_r [NUM_DIMS];
  logic [SIZE_BITS-1:0]  dim_size_nxt [NUM_DIMS];
  logic [SIZE_BITS-1:0]  position_r [NUM_DIMS];
  logic [SIZE_BITS-1:0]  position_nxt [NUM_DIMS];
  logic [SIZE_BITS-1:0]  stride_r [NUM_DIMS];
  logic [SIZE_BITS-1:0]  stride_nxt [NUM_DIMS];

  cmd_t                  cmd_r, cmd_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   offset_r, offset_nxt;
  logic [CNT_BITS-1:0]   size_r, size_nxt;
  logic [CNT_BITS-1:0]   step_r, step_nxt;
  logic [SUM_W-1:0]      carry_r, carry_nxt;
  logic [CNT_BITS-1:0]   used_r, used_nxt;
  logic                  more_r, more_nxt;
  status_t               status_r, status_nxt;

  logic [CNT_W-1:0]      n_act;
  logic                  act_run;
  logic [IDX_W-1:0]      cur_idx;
  logic [SIZE_BITS-1:0]  cur_size;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      sum_less;
  logic                  fast0;
  logic                  fast1;

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [CNT_BITS-1:0]   div_dividend;
  logic [CNT_BITS-1:0]   div_divisor;
  logic [CNT_BITS-1:0]   div_quo;
  logic [CNT_BITS-1:0]   div_rem;

  mrgw_div #(
    .W       (CNT_BITS),
    .SHORT_W (SUM_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .rsp       (div_rsp),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // active dimensions: nonzero sizes before the first zero
  always_comb begin
    n_act   = '0;
    act_run = 1'b1;
    for (int i = 0; i < NUM_DIMS; i++) begin
      act_run = act_run & (dim_size_r[i] != '0);
      if (act_run) n_act = n_act + CNT_W'(1);
    end
  end

  assign cur_idx  = idx_r[IDX_W-1:0];
  assign cur_size = dim_size_r[cur_idx];
  assign prod     = {{SIZE_BITS{1'b0}}, size_r} * {{CNT_BITS{1'b0}}, cur_size};
  assign sum      = SUM_W'(position_r[cur_idx]) + SUM_W'(stride_r[cur_idx]) + carry_r;
  assign sum_less = sum - SUM_W'(cur_size);
  assign fast0    = sum < SUM_W'(cur_size);
  assign fast1    = sum_less < SUM_W'(cur_size);

  always_comb begin
    dim_size_nxt = dim_size_r;
    if (cfg_valid) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        if (i < NUM_CFG && int'(cfg_index) == i) dim_size_nxt[i] = cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    launched_nxt = launched_r;
    position_nxt = position_r;
    stride_nxt   = stride_r;
    cmd_nxt      = cmd_r;
    count_nxt    = count_r;
    offset_nxt   = offset_r;
    size_nxt     = size_r;
    step_nxt     = step_r;
    carry_nxt    = carry_r;
    used_nxt     = used_r;
    more_nxt     = more_r;
    status_nxt   = status_r;
    div_req.start      = 1'b0;
    div_req.short_mode = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = cmd_t'(in_cmd);
          count_nxt  = in_sample_count;
          offset_nxt = in_start_offset;
          idx_nxt    = '0;
          more_nxt   = 1'b0;
          used_nxt   = '0;
          status_nxt = ST_OK;
          carry_nxt  = '0;
          size_nxt   = CNT_BITS'(1);
          if (in_cmd == CMD_ADVANCE) begin
            state_nxt = S_ADV;
          end else if (in_sample_count == '0) begin
            status_nxt = ST_ZERO_COUNT;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_PROD;
          end
        end
      end

      S_PROD: begin
        if (idx_r == n_act) begin
          state_nxt = S_CLIP;
        end else begin
          // grid size saturates at all ones
          if (prod > PROD_W'(CNT_MAX)) size_nxt = CNT_MAX;
          else size_nxt = prod[CNT_BITS-1:0];
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_CLIP: begin
        if (count_r > size_r) begin
          count_nxt  = size_r;
          status_nxt = ST_CLIPPED;
        end
        state_nxt = S_QDIV;
      end

      S_QDIV: begin
        div_dividend = size_r;
        div_divisor  = count_r;
        if (!launched_r) begin
          div_req.start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (div_rsp.done) begin
          launched_nxt = 1'b0;
          step_nxt     = div_quo;
          offset_nxt   = (offset_r > div_rem) ? div_rem : offset_r;
          // count * floor(size / count) is size minus the remainder
          used_nxt     = size_r - div_rem;
          for (int i = 0; i < NUM_DIMS; i++) begin
            position_nxt[i] = '0;
            stride_nxt[i]   = '0;
          end
          idx_nxt   = '0;
          state_nxt = S_SPLIT_OFF;
        end
      end

      S_SPLIT_OFF: begin
        div_dividend = offset_r;
        div_divisor  = CNT_BITS'(cur_size);
        if (idx_r == n_act) begin
          state_nxt = S_OUT;
        end else if (!launched_r) begin
          div_req.start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (div_rsp.done) begin
          launched_nxt          = 1'b0;
          position_nxt[cur_idx] = div_rem[SIZE_BITS-1:0];
          offset_nxt            = div_quo;
          state_nxt             = S_SPLIT_STEP;
        end
      end

      S_SPLIT_STEP: begin
        div_dividend = step_r;
        div_divisor  = CNT_BITS'(cur_size);
        if (!launched_r) begin
          div_req.start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (div_rsp.done) begin
          launched_nxt        = 1'b0;
          stride_nxt[cur_idx] = div_rem[SIZE_BITS-1:0];
          step_nxt            = div_quo;
          idx_nxt             = idx_r + CNT_W'(1);
          state_nxt           = S_SPLIT_OFF;
        end
      end

      S_ADV: begin
        if (idx_r == n_act) begin
          more_nxt  = (carry_r == '0);
          state_nxt = S_OUT;
        end else if (fast0) begin
          position_nxt[cur_idx] = sum[SIZE_BITS-1:0];
          carry_nxt             = '0;
          idx_nxt               = idx_r + CNT_W'(1);
        end else if (fast1) begin
          position_nxt[cur_idx] = sum_less[SIZE_BITS-1:0];
          carry_nxt             = SUM_W'(1);
          idx_nxt               = idx_r + CNT_W'(1);
        end else begin
          // digits out of range for the current sizes, short-mode divide
          state_nxt = S_ADV_DIV;
        end
      end

      S_ADV_DIV: begin
        div_dividend       = CNT_BITS'(sum);
        div_divisor        = CNT_BITS'(cur_size);
        div_req.short_mode = 1'b1;
        if (!launched_r) begin
          div_req.start = 1'b1;
          launched_nxt  = 1'b1;
        end else if (div_rsp.done) begin
          launched_nxt          = 1'b0;
          position_nxt[cur_idx] = div_rem[SIZE_BITS-1:0];
          carry_nxt             = div_quo[SUM_W-1:0];
          idx_nxt               = idx_r + CNT_W'(1);
          state_nxt             = S_ADV;
        end
      end

      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt    = S_IDLE;
        launched_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      launched_r <= 1'b0;
      for (int i = 0; i < NUM_DIMS; i++) begin
        dim_size_r[i] <= '0;
        position_r[i] <= '0;
        stride_r[i]   <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      launched_r <= launched_nxt;
      dim_size_r <= dim_size_nxt;
      position_r <= position_nxt;
      stride_r   <= stride_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    count_r  <= count_nxt;
    offset_r <= offset_nxt;
    size_r   <= size_nxt;
    step_r   <= step_nxt;
    carry_r  <= carry_nxt;
    used_r   <= used_nxt;
    more_r   <= more_nxt;
    status_r <= status_nxt;
  end

  logic [SIZE_BITS-1:0] pos_view [NUM_POS];

  for (genvar k = 0; k < NUM_POS; k++) begin : g_pos
    if (k < NUM_DIMS) begin : g_live
      assign pos_view[k] = position_r[k];
    end else begin : g_zero
      assign pos_view[k] = '0;
    end
  end

  assign cfg_ready      = 1'b1;
  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_pos_0      = pos_view[0];
  assign out_pos_1      = pos_view[1];
  assign out_pos_2      = pos_view[2];
  assign out_pos_3      = pos_view[3];
  assign out_more_left  = more_r;
  assign out_used_count = used_r;
  assign out_status     = status_r;

`ifndef SYNTH
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result beat is pending");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> launched_r)
    else $error("divider result with no pending request");

  a_adv_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd_r == CMD_ADVANCE) |-> (out_status == ST_OK && out_used_count == '0))
    else $error("advance beat carries setup fields");

  a_setup_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cmd_r == CMD_SETUP) |-> !out_more_left)
    else $error("setup beat reports more_left");
`endif

endmodule

`default_nettype wire

// ===== design/mrgw_div.sv =====
// mrgw_div: shared restoring divider, one quotient bit per cycle
// full mode runs W bits, short mode only the low SHORT_W bits; uses mrgw_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrgw_div #(
  parameter int W       = mrgw_pkg::CNT_BITS,
  parameter int SHORT_W = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mrgw_pkg::div_req_t  req,
  input  wire [W-1:0]         dividend,
  input  wire [W-1:0]         divisor,
  output mrgw_pkg::div_rsp_t  rsp,
  output logic [W-1:0]        quotient,
  output logic [W-1:0]        remainder
);
  import mrgw_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    trial;
  logic          fits;

  always_comb begin
    shifted  = {r_r, q_r[W-1]};
    trial    = shifted - {1'b0, d_r};
    fits     = ~trial[W];
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      d_nxt    = divisor;
      r_nxt    = '0;
      busy_nxt = 1'b1;
      if (req.short_mode) begin
        // park the short dividend at the top so only its bits get walked
        q_nxt   = dividend << (W - SHORT_W);
        cnt_nxt = CW'(SHORT_W);
      end else begin
        q_nxt   = dividend;
        cnt_nxt = CW'(W);
      end
    end else if (busy_r) begin
      r_nxt   = fits ? trial[W-1:0] : shifted[W-1:0];
      q_nxt   = {q_r[W-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

`default_nettype wire
